[rtl/core/assert_macros.svh]
// Assertion macros shared by the rod cutting RTL.
// Defining ASSERT_OFF compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rco_pkg.sv]
// Package for the rod cutting optimiser: widths, command codes, state and
// control types. No dependencies.
`timescale 1ns / 1ps
package rco_pkg;
   localparam int MAX_LEN     = 32;
   localparam int PRICE_W     = 16;
   localparam int IDX_W       = 5;
   localparam int LEN_W       = 6;
   localparam int REV_W       = 22;
   localparam int OUT_REV_W   = 21;
   localparam int CUT_W       = 5;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = 5;
   localparam int PADDR_W     = $clog2(MAX_LEN);
   localparam int DADDR_W     = $clog2(MAX_LEN + 1);
   localparam int DP_W        = REV_W + CUT_W;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_INIT  = 7'b0000010,
      ST_FILL  = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_TREAD = 7'b0010000,
      ST_TEMIT = 7'b0100000,
      ST_ZERO  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             en;
      logic             first;
      logic [CUT_W-1:0] cut;
   } acc_ctrl_type;
endpackage

[rtl/core/rco_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rco_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/rco_acc.sv]
// Shared add-compare unit: price plus sub-revenue, keeps best and first cut.
// Depends on rco_pkg.
`timescale 1ns / 1ps
module rco_acc (
   input  logic                        clock,
   input  rco_pkg::acc_ctrl_type       ctrl,
   input  logic [rco_pkg::PRICE_W-1:0] price,
   input  logic [rco_pkg::REV_W-1:0]   rev,
   output logic [rco_pkg::REV_W-1:0]   best_next,
   output logic [rco_pkg::CUT_W-1:0]   cut_next
);
   import rco_pkg::*;

   logic [REV_W-1:0] best_ff;
   logic [CUT_W-1:0] cut_ff;
   logic [REV_W-1:0] cand;

   assign cand = REV_W'(price) + rev;

   always_comb begin
      best_next = best_ff;
      cut_next  = cut_ff;
      if (ctrl.en && (ctrl.first || cand > best_ff)) begin
         best_next = cand;
         cut_next  = ctrl.cut;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_next;
      cut_ff  <= cut_next;
   end
endmodule

[rtl/core/rod_cutting_optimizer.sv]
// Rod cutting optimiser top level: sequencer, price and revenue tables.
// Depends on rco_pkg, rco_ram, rco_acc and assert_macros.svh.
//
// A solve of length n fills the revenue table with one add-compare per
// cycle in the fill state through a single shared unit, n(n+1)/2 in all,
// with a set-up state first and a drain state after each length, then
// traces back each piece with a table read state and a result state; busy
// stays high throughout. Results come one per rsp_strobe pulse and the
// receiver cannot hold them off.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rod_cutting_optimizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [rco_pkg::IDX_W-1:0]     req_piece_index,
   input  logic [rco_pkg::PRICE_W-1:0]   req_price,
   input  logic [rco_pkg::LEN_W-1:0]     req_rod_length,
   output logic                          rsp_strobe,
   output logic [rco_pkg::OUT_REV_W-1:0] rsp_best_revenue,
   output logic [rco_pkg::LEN_W-1:0]     rsp_piece_length,
   output logic                          rsp_last_piece
);
   import rco_pkg::*;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       n_ff, n_in;
   logic [LEN_W-1:0]       j_ff, j_in;
   logic [CUT_W-1:0]       i_ff, i_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   first_ff, first_in;
   logic [OUT_REV_W-1:0]   best_ff, best_in;
   logic [MAX_LEN-1:0]     pv_ff, pv_in;
   logic                   pv_rd_ff;
   logic                   d1_ff;
   logic [CUT_W-1:0]       i_d_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_REV_W-1:0]   rsp_rev_ff, rsp_rev_in;
   logic [LEN_W-1:0]       rsp_len_ff, rsp_len_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   p_we;
   logic [PRICE_W-1:0]     p_rdata;
   logic [PRICE_W-1:0]     price_eff;
   logic                   dp_we;
   logic [DADDR_W-1:0]     dp_waddr, dp_raddr;
   logic [DP_W-1:0]        dp_wdata, dp_rdata;
   logic [LEN_W-1:0]       fill_addr;
   acc_ctrl_type           acc_ctrl;
   logic [REV_W-1:0]       acc_best;
   logic [CUT_W-1:0]       acc_cut;
   logic [LEN_W-1:0]       piece, rem_next;
   logic [OUT_REV_W-1:0]   rev_now;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign p_we   = accept && (req_command == CMD_LOAD) &&
                   ({1'b0, req_piece_index} < (IDX_W + 1)'(MAX_LEN));

   rco_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_LEN)) u_price_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (req_piece_index[PADDR_W-1:0]),
      .wr_data (req_price),
      .rd_addr (i_ff[PADDR_W-1:0]),
      .rd_data (p_rdata)
   );

   assign price_eff = pv_rd_ff ? p_rdata : '0;
   assign fill_addr = j_ff - LEN_W'(1) - LEN_W'(i_ff);
   assign dp_raddr  = (state_ff == ST_FILL) ? fill_addr[DADDR_W-1:0]
                                            : rem_ff[DADDR_W-1:0];
   assign dp_we     = (state_ff == ST_INIT) || (state_ff == ST_DRAIN);
   assign dp_waddr  = (state_ff == ST_INIT) ? '0 : j_ff[DADDR_W-1:0];
   assign dp_wdata  = (state_ff == ST_INIT) ? '0 : {acc_best, acc_cut};

   rco_ram #(.WIDTH(DP_W), .DEPTH(MAX_LEN + 1)) u_dp_ram (
      .clock   (clock),
      .wr_en   (dp_we),
      .wr_addr (dp_waddr),
      .wr_data (dp_wdata),
      .rd_addr (dp_raddr),
      .rd_data (dp_rdata)
   );

   assign acc_ctrl.en    = d1_ff;
   assign acc_ctrl.first = (i_d_ff == '0);
   assign acc_ctrl.cut   = i_d_ff;

   rco_acc u_acc (
      .clock     (clock),
      .ctrl      (acc_ctrl),
      .price     (price_eff),
      .rev       (dp_rdata[DP_W-1:CUT_W]),
      .best_next (acc_best),
      .cut_next  (acc_cut)
   );

   // traceback of one piece
   always_comb begin
      piece = LEN_W'(dp_rdata[CUT_W-1:0]) + LEN_W'(1);
      if (piece > rem_ff) begin
         piece = rem_ff;
      end
      rem_next = rem_ff - piece;
      rev_now  = first_ff ? dp_rdata[CUT_W+OUT_REV_W-1:CUT_W] : best_ff;
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      pv_in         = pv_ff;
      rsp_strobe_in = 1'b0;
      rsp_rev_in    = rsp_rev_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (p_we) begin
               pv_in[req_piece_index[PADDR_W-1:0]] = 1'b1;
            end
            if (accept && req_command == CMD_SOLVE) begin
               n_in = (req_rod_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                         : req_rod_length;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            j_in = LEN_W'(1);
            i_in = '0;
            state_in = (n_ff == '0) ? ST_ZERO : ST_FILL;
         end
         ST_FILL: begin
            if (LEN_W'(i_ff) == j_ff - LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + CUT_W'(1);
            end
         end
         ST_DRAIN: begin
            i_in = '0;
            if (j_ff == n_ff) begin
               rem_in   = n_ff;
               cnt_in   = '0;
               first_in = 1'b1;
               state_in = ST_TREAD;
            end else begin
               j_in     = j_ff + LEN_W'(1);
               state_in = ST_FILL;
            end
         end
         ST_TREAD: begin
            state_in = ST_TEMIT;
         end
         ST_TEMIT: begin
            best_in       = rev_now;
            first_in      = 1'b0;
            rem_in        = rem_next;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_rev_in    = rev_now;
            rsp_len_in    = piece;
            rsp_last_in   = (rem_next == '0) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
            state_in      = rsp_last_in ? ST_IDLE : ST_TREAD;
         end
         ST_ZERO: begin
            rsp_strobe_in = 1'b1;
            rsp_rev_in    = '0;
            rsp_len_in    = '0;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pv_ff         <= '0;
         d1_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pv_ff         <= pv_in;
         d1_ff         <= (state_ff == ST_FILL);
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      first_ff    <= first_in;
      best_ff     <= best_in;
      pv_rd_ff    <= pv_ff[i_ff[PADDR_W-1:0]];
      i_d_ff      <= i_ff;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_best_revenue = rsp_rev_ff;
   assign rsp_piece_length = rsp_len_ff;
   assign rsp_last_piece   = rsp_last_ff;

   `ASSERT_NEXT(a_solve_busy, clock, reset, accept && req_command == CMD_SOLVE, busy)
   `ASSERT_NEXT(a_more_pieces, clock, reset, rsp_strobe && !rsp_last_piece, busy)
   `ASSERT_SAME(a_empty_last, clock, reset, rsp_strobe && rsp_piece_length == '0, rsp_last_piece)
   `ASSERT_SAME(a_fill_index, clock, reset, state_ff == ST_FILL, LEN_W'(i_ff) < j_ff)
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, busy || !d1_ff)
endmodule
